// File: rtl/covb_pkg.sv
// Package for the coverage resolve and alpha blend block.
// Item types, the front-to-back queue entry and fixed constants; no dependencies.
package covb_pkg;

  localparam int unsigned RunW     = 20;
  localparam int unsigned CovMaxW  = 17;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [RunW-1:0] RunMax = 20'h7FFFF;
  localparam logic [RunW-1:0] RunMin = 20'h80000;

  typedef enum logic {
    RegFillColor = 1'b0,
    RegFillAlpha = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] coverage_delta;
    logic [31:0]        dest_pixel;
    logic               row_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_pixel;
    logic        write_enable;
    logic        row_done;
  } out_item_t;

  typedef struct packed {
    logic [CovMaxW-1:0] cov;
    logic               visible;
    logic               snap;
    logic [31:0]        dest_pixel;
    logic               row_end;
  } cls_item_t;

  function automatic logic [7:0] blend_chan(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    logic [15:0] acc;
    acc = 16'(s * a) + 16'(d * (8'd255 - a));
    return acc[15:8];
  endfunction

endpackage

// File: rtl/covb_front.sv
// Front part: accepts items, keeps the saturating running coverage sum and
// classifies each item for the back part. Depends on covb_pkg.
module covb_front import covb_pkg::*; #(
  parameter int unsigned COV_FRAC_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output cls_item_t cls_o
);

  localparam int unsigned CovW = COV_FRAC_BITS + 1;
  localparam logic [RunW-1:0] One    = RunW'(1 << COV_FRAC_BITS);
  localparam logic [RunW-1:0] MinVis = RunW'((1 << COV_FRAC_BITS) >> 9);
  localparam logic [RunW-1:0] Snap   =
    RunW'((1 << COV_FRAC_BITS) - ((1 << COV_FRAC_BITS) >> 8));

  logic [RunW-1:0] run_q, run_d;
  logic [RunW:0]   sum_wide;
  logic [RunW-1:0] sum_sat;
  logic [RunW-1:0] abs_v;
  logic [CovW-1:0] cov;

  always_comb begin
    sum_wide = {run_q[RunW-1], run_q} +
               {{(RunW-15){item_i.coverage_delta[15]}}, item_i.coverage_delta};
    if (sum_wide[RunW] != sum_wide[RunW-1]) begin
      sum_sat = sum_wide[RunW] ? RunMin : RunMax;
    end else begin
      sum_sat = sum_wide[RunW-1:0];
    end
    abs_v = sum_sat[RunW-1] ? (~sum_sat + 1'b1) : sum_sat;
    cov   = (abs_v > One) ? One[CovW-1:0] : abs_v[CovW-1:0];

    cls_o.cov        = CovMaxW'(cov);
    cls_o.visible    = abs_v > MinVis;
    cls_o.snap       = RunW'(cov) >= Snap;
    cls_o.dest_pixel = item_i.dest_pixel;
    cls_o.row_end    = item_i.row_end;

    run_d = run_q;
    if (accept_i) begin
      run_d = item_i.row_end ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

// File: rtl/covb_queue.sv
// Two-entry queue between the front and back parts.
// Depends on covb_pkg.
module covb_queue import covb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output cls_item_t data_o,
  output logic      empty_o
);

  cls_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/covb_back.sv
// Back part: alpha scaling stage, then source-over blend into the result register.
// Depends on covb_pkg.
module covb_back import covb_pkg::*; #(
  parameter int unsigned COV_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] fill_color_i,
  input  logic [7:0]  fill_alpha_i,
  input  cls_item_t   cls_i,
  input  logic        cls_empty_i,
  output logic        cls_pop_o,
  output out_item_t   result_o,
  output logic        empty_o,
  input  logic        pop_i
);

  localparam int unsigned CovW  = COV_FRAC_BITS + 1;
  localparam int unsigned ProdW = COV_FRAC_BITS + 9;
  localparam logic [ProdW-1:0] Half = ProdW'(1 << (COV_FRAC_BITS - 1));

  logic        s1_valid_q;
  logic [7:0]  a_q;
  logic        wa_q;
  logic [31:0] dest_q;
  logic        row_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic             adv_out, take;
  logic [ProdW-1:0] prod;
  logic [ProdW-COV_FRAC_BITS-1:0] scaled;
  logic [7:0]       a_d;
  logic [31:0]      src, blended;

  assign adv_out   = s1_valid_q && (!out_valid_q || pop_i);
  assign take      = !s1_valid_q || adv_out;
  assign cls_pop_o = take && !cls_empty_i;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_comb begin
    prod   = ProdW'(fill_alpha_i) * ProdW'(cls_i.cov[CovW-1:0]) + Half;
    scaled = prod[ProdW-1:COV_FRAC_BITS];
    if (cls_i.snap) begin
      a_d = fill_alpha_i;
    end else if (scaled > 9'd255) begin
      a_d = 8'd255;
    end else begin
      a_d = scaled[7:0];
    end
  end

  always_comb begin
    src = {8'hFF, fill_color_i};
    if (a_q == 8'd255) begin
      blended = src;
    end else begin
      blended = {blend_chan(src[31:24], dest_q[31:24], a_q),
                 blend_chan(src[23:16], dest_q[23:16], a_q),
                 blend_chan(src[15:8],  dest_q[15:8],  a_q),
                 blend_chan(src[7:0],   dest_q[7:0],   a_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_pop_o) begin
      a_q    <= a_d;
      wa_q   <= cls_i.visible && (a_d != 8'd0);
      dest_q <= cls_i.dest_pixel;
      row_q  <= cls_i.row_end;
    end
    if (adv_out) begin
      out_q.new_pixel    <= wa_q ? blended : dest_q;
      out_q.write_enable <= wa_q;
      out_q.row_done     <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) s1_valid_q <= cls_pop_o;
      if (adv_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/coverage_resolve_alpha_blend.sv
// Top level of the coverage resolve and source-over blend block.
// Holds the configuration registers; uses covb_pkg, covb_front, covb_queue, covb_back.
//
// Usage:
//   Input items (coverage delta, destination pixel, row end) are pushed with
//   push while full is low. Each item yields exactly one result item
//   (new pixel, write enable, row done), shown while empty is low and taken
//   with pop.
//   A pushed item passes the queue write, then the alpha scaling stage, then
//   the blend register before it is visible on the result ports.
//   Throughput: one item per cycle while nothing stalls; the running coverage
//   add and saturate in the front part and the 8x8 blend products in the back
//   part are combinational. When pop is held low the result register, the
//   scaling stage and the two-entry queue fill in turn, then full rises;
//   nothing is lost. Reset clears the running coverage and all valid flags;
//   fill colour resets to 0 and fill alpha to 255. Registers are written over
//   the APB-style port at byte 0 (fill colour) and byte 4 (fill alpha); the
//   user must write them only while the block is idle, which the block itself
//   does not enforce.
module coverage_resolve_alpha_blend import covb_pkg::*; #(
  parameter int unsigned COV_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [23:0] fill_color_q;
  logic [7:0]  fill_alpha_q;
  logic        cfg_we;
  cfg_reg_e    cfg_sel;
  logic        accept;
  cls_item_t   cls, q_data;
  logic        q_full, q_empty, q_pop;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      RegFillColor: prdata = {8'h00, fill_color_q};
      RegFillAlpha: prdata = {24'h0, fill_alpha_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= '0;
      fill_alpha_q <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        RegFillColor: fill_color_q <= pwdata[23:0];
        RegFillAlpha: fill_alpha_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  covb_front #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cls_o    (cls)
  );

  covb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cls),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  covb_back #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_color_i (fill_color_q),
    .fill_alpha_i (fill_alpha_q),
    .cls_i        (q_data),
    .cls_empty_i  (q_empty),
    .cls_pop_o    (q_pop),
    .result_o     (result_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule
